// ===== rtl/core/flc_pkg.sv =====
// Shared types and constants for the full linear convolution filter.
package flc_pkg;

	// fixed field widths
	localparam int TAP_IDX_BITS   = 4;
	localparam int VALUE_BITS_IN  = 16;
	localparam int TAP_COUNT_BITS = 5;
	localparam int SUM_BITS       = 40;

	// stream command codes
	localparam logic CMD_TAP    = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// register index (bit 2 of the byte address)
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef enum logic {
		KIND_TAP,
		KIND_SAMPLE
	} kind_t;

	// classified request between front and back
	typedef struct packed {
		kind_t                            kind;
		logic [TAP_IDX_BITS-1:0]          tap_index;
		logic signed [VALUE_BITS_IN-1:0]  value;
		logic                             last;
	} item_t;

	// one result waiting for the output
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		logic                       last;
	} res_t;

	// tag that travels beside the products
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

// ===== rtl/core/flc_queue.sv =====
// Small register FIFO with full and empty flags.
module flc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	assign empty   = (wr_q == rd_q);
	assign full    = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
	assign rd_data = mem_q[rd_q[AW-1:0]];

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= rd_q + 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q[AW-1:0]] <= wr_data;
	end

endmodule

// ===== rtl/core/flc_front.sv =====
// Input side: takes stream requests, classifies them and drops dead tap writes.
module flc_front
	import flc_pkg::*;
#(
	parameter int TAPS        = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [23:0]              s_axis_tdata,
	input  logic                     s_axis_tuser,
	input  logic                     s_axis_tlast,
	input  logic                     q_full,
	output logic                     q_push,
	output item_t                    q_item
);

	localparam int VB = (SAMPLE_BITS < VALUE_BITS_IN) ? SAMPLE_BITS : VALUE_BITS_IN;

	logic [TAP_IDX_BITS-1:0]  idx;
	logic signed [VB-1:0]     val_trim;
	logic                     is_tap;
	logic                     drop;

	assign idx      = s_axis_tdata[TAP_IDX_BITS-1:0];
	assign val_trim = s_axis_tdata[TAP_IDX_BITS +: VB];
	assign is_tap   = (s_axis_tuser == CMD_TAP);

	// a tap write past the table end has no effect
	assign drop = is_tap && (32'(idx) >= TAPS);

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full && !drop;

	always_comb begin
		q_item.kind      = is_tap ? KIND_TAP : KIND_SAMPLE;
		q_item.tap_index = idx;
		q_item.value     = VALUE_BITS_IN'(val_trim);
		q_item.last      = s_axis_tlast && !is_tap;
	end

endmodule

// ===== rtl/core/flc_tree.sv =====
// Registered adder tree over the tap products, one register per level.
module flc_tree
	import flc_pkg::*;
#(
	parameter int TAPS = 16,
	parameter int PW   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [PW-1:0]       prod [TAPS],
	input  tag_t                       tag_in,
	output logic signed [SUM_BITS-1:0] sum,
	output tag_t                       tag_out
);

	localparam int LEVELS = $clog2(TAPS);
	localparam int NP     = 2 ** LEVELS;

	logic signed [SUM_BITS-1:0] leaf   [NP];
	logic signed [SUM_BITS-1:0] node_q [LEVELS][NP/2];
	tag_t                       tag_q  [LEVELS];

	// widen products, pad to a power of two
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			if (i < TAPS)
				leaf[i] = SUM_BITS'(prod[i]);
			else
				leaf[i] = '0;
		end
	end

	// pairwise sums, halving each level
	always_ff @(posedge clk) begin
		for (int i = 0; i < NP/2; i++)
			node_q[0][i] <= leaf[2*i] + leaf[2*i+1];
		for (int l = 1; l < LEVELS; l++) begin
			for (int i = 0; i < NP/2; i++) begin
				if (i < (NP >> (l + 1)))
					node_q[l][i] <= node_q[l-1][2*i] + node_q[l-1][2*i+1];
			end
		end
	end

	// tags follow the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++)
				tag_q[l] <= '0;
		end else begin
			tag_q[0] <= tag_in;
			for (int l = 1; l < LEVELS; l++)
				tag_q[l] <= tag_q[l-1];
		end
	end

	assign sum     = node_q[LEVELS-1][0];
	assign tag_out = tag_q[LEVELS-1];

endmodule

// ===== rtl/core/flc_engine.sv =====
// Back side: tap table, delay line, tail sequencer and product stage.
module flc_engine
	import flc_pkg::*;
#(
	parameter int TAPS        = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int OUT_DEPTH   = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [TAP_COUNT_BITS-1:0] tap_count,
	input  item_t                     item,
	input  logic                      item_valid,
	output logic                      item_pop,
	input  logic                      out_pop,
	output logic                      res_push,
	output res_t                      res
);

	localparam int VB = (SAMPLE_BITS < VALUE_BITS_IN) ? SAMPLE_BITS : VALUE_BITS_IN;
	localparam int PW = 2 * VB;
	localparam int MW = $clog2(TAPS + 1);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic signed [VB-1:0] coef_q [TAPS];
	logic signed [VB-1:0] dly_q  [TAPS-1];
	logic signed [VB-1:0] win    [TAPS];
	logic signed [PW-1:0] prod_s1 [TAPS];
	tag_t                 tag_s1;
	tag_t                 tag_out;
	logic signed [SUM_BITS-1:0] sum_out;

	logic [MW-1:0] m_use;
	logic [MW-1:0] tail_q;
	logic [CW-1:0] crd_q;
	logic          in_tail;
	logic          has_crd;
	logic          step;
	logic          final_step;
	logic          is_tap;
	logic          tap_we;
	logic signed [VB-1:0] sample;

	// taps in use: zero acts as one, clipped to the table size
	always_comb begin
		if (tap_count == '0)
			m_use = MW'(1);
		else if (32'(tap_count) > TAPS)
			m_use = MW'(TAPS);
		else
			m_use = MW'(tap_count);
	end

	// issue control
	assign in_tail  = (tail_q != '0);
	assign has_crd  = (crd_q != '0);
	assign is_tap   = (item.kind == KIND_TAP);
	assign item_pop = !in_tail && item_valid && (is_tap || has_crd);
	assign tap_we   = item_pop && is_tap;
	assign step     = in_tail ? has_crd : (item_pop && !is_tap);
	assign sample   = in_tail ? '0 : item.value[VB-1:0];

	always_comb begin
		if (in_tail)
			final_step = (tail_q == MW'(1));
		else
			final_step = item.last && (m_use == MW'(1));
	end

	// tail counter: taps-1 zero-sample steps after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= '0;
		end else if (in_tail) begin
			if (has_crd)
				tail_q <= tail_q - 1'b1;
		end else if (step && item.last && (m_use != MW'(1))) begin
			tail_q <= m_use - 1'b1;
		end
	end

	// output slots not yet claimed by an in-flight or buffered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			crd_q <= CW'(OUT_DEPTH);
		else
			crd_q <= crd_q - CW'(step) + CW'(out_pop);
	end

	// coefficient table
	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			if (tap_we && (32'(item.tap_index) == k))
				coef_q[k] <= item.value[VB-1:0];
		end
	end

	// delay line: shift on each step, cleared after the final output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS-1; k++)
				dly_q[k] <= '0;
		end else if (step) begin
			if (final_step) begin
				for (int k = 0; k < TAPS-1; k++)
					dly_q[k] <= '0;
			end else begin
				dly_q[0] <= sample;
				for (int k = 1; k < TAPS-1; k++)
					dly_q[k] <= dly_q[k-1];
			end
		end
	end

	// window: newest sample first
	always_comb begin
		win[0] = sample;
		for (int k = 1; k < TAPS; k++)
			win[k] = dly_q[k-1];
	end

	// product stage, taps past the kernel length give zero
	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			if (32'(m_use) > k)
				prod_s1[k] <= coef_q[k] * win[k];
			else
				prod_s1[k] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= step;
			tag_s1.last  <= final_step;
		end
	end

	// sum fits in 40 bits for any legal size, no clipping needed
	flc_tree #(
		.TAPS (TAPS),
		.PW   (PW)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod    (prod_s1),
		.tag_in  (tag_s1),
		.sum     (sum_out),
		.tag_out (tag_out)
	);

	assign res_push = tag_out.valid;
	assign res.sum  = sum_out;
	assign res.last = tag_out.last;

endmodule

// ===== rtl/core/full_linear_convolution.sv =====
// Top level of the streaming full linear convolution filter.
//
// Input stream (s_axis): tuser = 0 writes kernel tap tap_index with value,
// tuser = 1 feeds a sample; tlast on a sample ends the sequence. For each
// sample one sum of products over tap_count taps comes out on m_axis; after
// the last sample, tap_count-1 tail sums follow with zeros shifted in, and
// the final one carries tlast. The delay line is then cleared.
// APB register 0 (byte address 0) is tap_count, 1..TAPS, reset 16; write it
// only while the filter is idle. Taps must be written before use.
// An accepted sample moves out of the input queue into the product
// register, through one register per adder tree level, and into the
// output buffer, where its result becomes valid.
// Throughput: one request per cycle while output buffer slots are free.
// The last sample holds the back side for tap_count-1 tail steps, while
// the input queue keeps taking requests until it is full.
// Reset empties both queues, clears the delay line and sets tap_count to 16.
// When m_axis_tready is low, results collect in the output buffer; the
// back side stops issuing samples once every buffer slot is claimed, and
// then the input queue fills and s_axis_tready drops.
module full_linear_convolution
	import flc_pkg::*;
#(
	parameter int TAPS        = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [3:0] tap_index, [19:4] value, [23:20] zero
	input  logic        s_axis_tuser,  // cmd
	input  logic        s_axis_tlast,  // last
	// stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [39:0] sum_value
	output logic        m_axis_tlast,  // last_out
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LEVELS    = $clog2(TAPS);
	localparam int OUT_DEPTH = 2 ** $clog2(LEVELS + 3);
	localparam int IN_DEPTH  = 4;

	logic [TAP_COUNT_BITS-1:0] tap_count_q;
	logic  in_push, in_full, in_empty, in_pop;
	item_t in_item, q_item;
	logic  res_push, out_full, out_empty, out_pop;
	res_t  res, out_res;

	// register port, byte offset bits ignored
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TAP_COUNT) ? 32'(tap_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tap_count_q <= TAP_COUNT_BITS'(16);
		else if (psel && penable && pwrite && pready && (paddr[2] == REG_TAP_COUNT))
			tap_count_q <= pwdata[TAP_COUNT_BITS-1:0];
	end

	flc_front #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (in_full),
		.q_push        (in_push),
		.q_item        (in_item)
	);

	flc_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_push),
		.wr_data (in_item),
		.pop     (in_pop),
		.rd_data (q_item),
		.full    (in_full),
		.empty   (in_empty)
	);

	flc_engine #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.OUT_DEPTH   (OUT_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.tap_count  (tap_count_q),
		.item       (q_item),
		.item_valid (!in_empty),
		.item_pop   (in_pop),
		.out_pop    (out_pop),
		.res_push   (res_push),
		.res        (res)
	);

	// output buffer, never overruns thanks to the engine's slot count
	flc_queue #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res),
		.pop     (out_pop),
		.rd_data (out_res),
		.full    (out_full),
		.empty   (out_empty)
	);

	assign out_pop       = m_axis_tvalid && m_axis_tready && !out_full | (m_axis_tvalid && m_axis_tready);
	assign m_axis_tvalid = !out_empty;
	assign m_axis_tdata  = out_res.sum;
	assign m_axis_tlast  = out_res.last;

endmodule

// ===== rtl/core/flc_checker.sv =====
// Port-level checks for the convolution filter, bound to the top level.
module flc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// reset leaves the output empty and the input open
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid && s_axis_tready)
		else $error("bad state in reset");

	// a tap_count write reads back on the next cycle
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=>
			paddr[2] || (prdata[4:0] == $past(pwdata[4:0])))
		else $error("tap_count readback mismatch");

	// unused register bits read as zero
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:5] == '0)
		else $error("nonzero reserved read bits");

endmodule

bind full_linear_convolution flc_checker u_flc_checker (.*);

// ===== test/full_linear_convolution_tb.sv =====
// Self-checking testbench for the streaming full linear convolution filter.
module full_linear_convolution_tb;
	import flc_pkg::*;

	localparam int TAPS          = 16;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [2:0] ADDR_TAP_COUNT = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;
	localparam longint SUM_MAX = (longint'(1) <<< (SUM_BITS - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [3:0] tap_index, [19:4] value, [23:20] zero
	logic        s_axis_tuser = 1'b0; // cmd
	logic        s_axis_tlast = 1'b0; // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [39:0] sum_value
	logic        m_axis_tlast;        // last_out
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// model state: kernel, delay line, kernel length register
	logic signed [15:0] kernel [TAPS];
	logic signed [15:0] history [TAPS-1] = '{default: '0};
	logic [4:0]         tap_count_reg = 5'd16;
	res_t               expected_sums [$];

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned requests_sent = 0;
	int unsigned results_checked = 0;
	int unsigned config_writes = 0;

	full_linear_convolution #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (16)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("full_linear_convolution_tb failed");
		$finish;
	end

	// kernel length actually used: zero acts as one, above TAPS clamps
	function automatic int unsigned active_taps();
		if (tap_count_reg == 0)
			return 1;
		if (tap_count_reg > TAPS)
			return TAPS;
		return tap_count_reg;
	endfunction

	// one filter step: sum with smp as newest input, then shift it in
	function automatic logic signed [39:0] convolve_step(logic signed [15:0] smp,
			int unsigned m);
		longint acc;
		acc = longint'(kernel[0]) * longint'(smp);
		for (int k = 1; k < m; k++)
			acc += longint'(kernel[k]) * longint'(history[k-1]);
		for (int k = TAPS - 2; k > 0; k--)
			history[k] = history[k-1];
		history[0] = smp;
		if (acc > SUM_MAX)
			acc = SUM_MAX;
		if (acc < SUM_MIN)
			acc = SUM_MIN;
		return acc[39:0];
	endfunction

	// update the model for one accepted request and queue its sums
	function automatic void predict_request(logic cmd, logic [3:0] idx,
			logic signed [15:0] val, logic last);
		int unsigned m;
		res_t r;
		if (cmd == CMD_TAP) begin
			kernel[idx] = val;
			return;
		end
		m = active_taps();
		r.sum  = convolve_step(val, m);
		r.last = last && (m == 1);
		expected_sums.push_back(r);
		if (!last)
			return;
		// tail flush with zeros shifted in
		for (int unsigned t = 1; t < m; t++) begin
			r.sum  = convolve_step(16'sd0, m);
			r.last = (t == m - 1);
			expected_sums.push_back(r);
		end
		for (int k = 0; k < TAPS - 1; k++)
			history[k] = '0;
	endfunction

	// sample value with extra weight on the corners
	function automatic logic [15:0] pick_value();
		case ($urandom_range(11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// send one request, with random idle cycles in front
	task automatic send_request(logic cmd, logic [3:0] idx, logic [15:0] val, logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 24'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, val, idx};
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_request(cmd, idx, val, last);
		requests_sent++;
	endtask

	// stop sending, wait for all sums, then let queued tap writes settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup then access cycle
	task automatic write_register(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_TAP_COUNT)
			tap_count_reg = data[4:0];
		config_writes++;
	endtask

	// receiver: compare each sum with the oldest expectation, random stalls
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_sums.size() == 0) begin
				$error("unexpected result: sum_value=%0d last_out=%0b",
					$signed(m_axis_tdata), m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_sums.pop_front();
				if (m_axis_tdata !== want.sum) begin
					$error("sum_value: expected %0d, got %0d", want.sum,
						$signed(m_axis_tdata));
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_out: expected %0b, got %0b", want.last, m_axis_tlast);
					fail_count++;
				end
				results_checked++;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// load every tap, corners on the first and last, one with last set
	task automatic test_kernel_load();
		send_request(CMD_TAP, 4'd0, 16'h7FFF, 1'b0);
		send_request(CMD_TAP, 4'd1, 16'h8000, 1'b0);
		send_request(CMD_TAP, 4'd2, pick_value(), 1'b1);
		for (int i = 3; i < TAPS - 1; i++)
			send_request(CMD_TAP, 4'(i), pick_value(), 1'b0);
		send_request(CMD_TAP, 4'(TAPS - 1), 16'h8000, 1'b0);
	endtask

	// reset kernel length, sample corners
	task automatic test_full_length_extremes();
		send_request(CMD_SAMPLE, 4'($urandom), 16'h8000, 1'b0);
		send_request(CMD_SAMPLE, 4'($urandom), 16'h7FFF, 1'b0);
		send_request(CMD_SAMPLE, 4'($urandom), 16'h8000, 1'b1);
		wait_idle();
	endtask

	// one tap: the sample's own sum is the final one
	task automatic test_single_tap();
		write_register(ADDR_TAP_COUNT, 32'd1);
		send_request(CMD_SAMPLE, 4'($urandom), 16'h7FFF, 1'b1);
		wait_idle();
	endtask

	// length zero, length above TAPS, unmapped address
	task automatic test_length_clamp();
		write_register(ADDR_TAP_COUNT, 32'hFFFF_FFE0);
		send_request(CMD_SAMPLE, 4'($urandom), 16'h8000, 1'b1);
		wait_idle();
		write_register(ADDR_TAP_COUNT, 32'd20);
		write_register(ADDR_UNMAPPED, 32'd3);
		send_request(CMD_SAMPLE, 4'($urandom), 16'h7FFF, 1'b1);
		wait_idle();
	endtask

	// length changed inside a sequence keeps the delay line
	task automatic test_resize_mid_sequence();
		write_register(ADDR_TAP_COUNT, 32'd16);
		send_request(CMD_SAMPLE, 4'($urandom), pick_value(), 1'b0);
		send_request(CMD_SAMPLE, 4'($urandom), pick_value(), 1'b0);
		wait_idle();
		write_register(ADDR_TAP_COUNT, 32'd5);
		send_request(CMD_SAMPLE, 4'($urandom), pick_value(), 1'b1);
		wait_idle();
	endtask

	// random sequences with random kernel lengths and stray tap writes
	task automatic test_random_sequences(int unsigned n_items, int unsigned idle_pct,
			int unsigned stall_pct);
		int unsigned sent;
		int unsigned n_samples;
		logic [4:0]  len;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			wait_idle();
			case ($urandom_range(3))
				0: len = 5'd1;
				1: len = 5'd16;
				default: len = 5'($urandom_range(1, 16));
			endcase
			write_register(ADDR_TAP_COUNT, {27'($urandom), len});
			repeat ($urandom_range(3)) begin
				send_request(CMD_TAP, 4'($urandom), pick_value(), 1'($urandom));
				sent++;
			end
			n_samples = $urandom_range(1, 10);
			for (int unsigned i = 0; i < n_samples; i++) begin
				if ($urandom_range(9) == 0) begin
					send_request(CMD_TAP, 4'($urandom), pick_value(), 1'($urandom));
					sent++;
				end
				// mostly closed sequences; an open one carries over to the next length
				send_request(CMD_SAMPLE, 4'($urandom), pick_value(),
					(i == n_samples - 1) && ($urandom_range(7) != 0));
				sent++;
			end
		end
		wait_idle();
	endtask

	// test sequence
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_kernel_load();
		test_full_length_extremes();
		test_single_tap();
		test_length_clamp();
		test_resize_mid_sequence();

		test_random_sequences(60, 0, 0);
		test_random_sequences(60, 63, 0);
		test_random_sequences(60, 0, 63);
		test_random_sequences(50, 13, 13);

		$display("Sent %0d requests and %0d register writes; checked %0d sums", requests_sent,
			config_writes, results_checked);
		$display("Kernel lengths 1..16, clamped lengths, open sequences, four idle mixes");
		if (expected_sums.size() != 0) begin
			$error("%0d expected sums never arrived", expected_sums.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("full_linear_convolution_tb passed");
		else
			$display("full_linear_convolution_tb failed");
		$finish;
	end

endmodule

// ===== full_linear_convolution.f =====
rtl/core/flc_pkg.sv
rtl/core/flc_queue.sv
rtl/core/flc_front.sv
rtl/core/flc_tree.sv
rtl/core/flc_engine.sv
rtl/core/full_linear_convolution.sv
rtl/core/flc_checker.sv
test/full_linear_convolution_tb.sv
